>>> sv/mocs_pkg.sv
// Shared widths, register indexes and reset constants of the clock offset estimator.
package mocs_pkg;

   localparam int LOCAL_W  = 63;
   localparam int TIME_W   = 64;
   localparam int LEN_W    = 8;
   localparam int WIN_W    = 10;
   localparam int COUNT_W  = 11;
   localparam int DELAY_W  = 16;
   localparam int TOL_W    = 16;
   localparam int TMO_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [LEN_W-1:0] MIN_MSG_LEN = LEN_W'(8);

   localparam logic [WIN_W-1:0]   INITIAL_WINDOW_RST   = WIN_W'(800);
   localparam logic [WIN_W-1:0]   RESYNC_WINDOW_RST    = WIN_W'(200);
   localparam logic [DELAY_W-1:0] LINK_DELAY_RST       = DELAY_W'(240);
   localparam logic [TOL_W-1:0]   ACCEPT_TOLERANCE_RST = TOL_W'(150);
   localparam logic [TMO_W-1:0]   DESYNC_TIMEOUT_RST   = TMO_W'(30000000);

   localparam logic [TIME_W-1:0] TIME_MAX_POS = {1'b0, {(TIME_W-1){1'b1}}};

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CHECK  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INITIAL_WINDOW   = 3'd0,
      CSR_RESYNC_WINDOW    = 3'd1,
      CSR_LINK_DELAY       = 3'd2,
      CSR_ACCEPT_TOLERANCE = 3'd3,
      CSR_DESYNC_TIMEOUT   = 3'd4
   } csr_index_type;

endpackage

>>> sv/mocs_req_if.sv
// Input channel carrying sample and check items.
interface mocs_req_if import mocs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic [LOCAL_W-1:0]       local_time;
   logic signed [TIME_W-1:0] remote_time;
   logic [LEN_W-1:0]         message_len;

   modport source (output valid, op, local_time, remote_time, message_len, input ready);
   modport sink   (input valid, op, local_time, remote_time, message_len, output ready);
endinterface

>>> sv/mocs_rsp_if.sv
// Result channel carrying the sync state after each item.
interface mocs_rsp_if import mocs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     is_synced;
   logic signed [TIME_W-1:0] clock_offset;
   logic signed [TIME_W-1:0] synced_time;
   logic                     offset_updated;
   logic                     window_rejected;
   logic                     sync_cleared;

   modport source (output valid, is_synced, clock_offset, synced_time, offset_updated,
                   window_rejected, sync_cleared, input ready);
   modport sink   (input valid, is_synced, clock_offset, synced_time, offset_updated,
                   window_rejected, sync_cleared, output ready);
endinterface

>>> sv/mocs_csr_if.sv
// Configuration write channel.
interface mocs_csr_if import mocs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/min_offset_clock_sync.sv
// A result passes through the input, state and output stage registers before it is valid.
// Throughput: one item per cycle while the result channel is ready; the offset and window state
// close their loop within the state stage, so every item sees the state left by the one before it.
// Each stage holds its item until the next one is free, so bubbles collapse under stalls.
// Reset (synchronous, active high) restores the register defaults, clears the offset and
// window state and empties the pipeline.
module min_offset_clock_sync import mocs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mocs_req_if.sink   req_chan,
   mocs_rsp_if.source rsp_chan,
   mocs_csr_if.sink   csr_chan
);

   // Configuration registers.
   logic [WIN_W-1:0]   initial_window_ff;
   logic [WIN_W-1:0]   resync_window_ff;
   logic [DELAY_W-1:0] link_delay_ff;
   logic [TOL_W-1:0]   accept_tolerance_ff;
   logic [TMO_W-1:0]   desync_timeout_ff;

   // Estimator state.
   logic [TIME_W-1:0]  offset_ff,      offset_in;
   logic [LOCAL_W-1:0] last_calib_ff,  last_calib_in;
   logic [TIME_W-1:0]  window_min_ff,  window_min_in;
   logic [COUNT_W-1:0] count_ff,       count_in;
   logic               synced_ff,      synced_in;

   // Pipeline stages.
   logic               s1_valid_ff;
   logic               s1_op_ff;
   logic               s1_len_ok_ff;
   logic [LOCAL_W-1:0] s1_local_ff;
   logic [TIME_W-1:0]  s1_diff_ff;

   logic               s2_valid_ff;
   logic               s2_synced_ff;
   logic [TIME_W-1:0]  s2_offset_ff;
   logic [LOCAL_W-1:0] s2_local_ff;
   logic               s2_updated_ff;
   logic               s2_rejected_ff;
   logic               s2_cleared_ff;

   logic               rsp_valid_ff;
   logic               rsp_synced_ff;
   logic [TIME_W-1:0]  rsp_offset_ff;
   logic [TIME_W-1:0]  rsp_time_ff;
   logic               rsp_updated_ff;
   logic               rsp_rejected_ff;
   logic               rsp_cleared_ff;

   logic s3_ready, s2_ready, s1_ready, move12;
   logic updated_in, rejected_in, cleared_in;

   // Datapath terms of the state stage.
   logic               min_less;
   logic [TIME_W-1:0]  min_next;
   logic [COUNT_W-1:0] count_next;
   logic               window_close;
   logic [TIME_W-1:0]  delay_ext, tol_ext, neg_tol, base, dev;
   logic               in_tol;
   logic [LOCAL_W-1:0] calib_age;
   logic               timed_out;

   assign s3_ready = !rsp_valid_ff || rsp_chan.ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign move12   = s1_valid_ff && s2_ready;

   assign req_chan.ready = s1_ready;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_window_ff   <= INITIAL_WINDOW_RST;
         resync_window_ff    <= RESYNC_WINDOW_RST;
         link_delay_ff       <= LINK_DELAY_RST;
         accept_tolerance_ff <= ACCEPT_TOLERANCE_RST;
         desync_timeout_ff   <= DESYNC_TIMEOUT_RST;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_INITIAL_WINDOW:   initial_window_ff   <= csr_chan.data[WIN_W-1:0];
            CSR_RESYNC_WINDOW:    resync_window_ff    <= csr_chan.data[WIN_W-1:0];
            CSR_LINK_DELAY:       link_delay_ff       <= csr_chan.data[DELAY_W-1:0];
            CSR_ACCEPT_TOLERANCE: accept_tolerance_ff <= csr_chan.data[TOL_W-1:0];
            CSR_DESYNC_TIMEOUT:   desync_timeout_ff   <= csr_chan.data[TMO_W-1:0];
            default: ;
         endcase
      end
   end

   // The difference needs no state, so it is formed on the way into the first stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (s1_ready) begin
         s1_op_ff     <= req_chan.op;
         s1_len_ok_ff <= req_chan.message_len >= MIN_MSG_LEN;
         s1_local_ff  <= req_chan.local_time;
         s1_diff_ff   <= {1'b0, req_chan.local_time} - req_chan.remote_time;
      end
   end

   always_comb begin
      delay_ext  = {{(TIME_W-DELAY_W){1'b0}}, link_delay_ff};
      tol_ext    = {{(TIME_W-TOL_W){1'b0}}, accept_tolerance_ff};
      neg_tol    = TIME_W'(0) - tol_ext;
      min_less   = $signed(s1_diff_ff) < $signed(window_min_ff);
      min_next   = min_less ? s1_diff_ff : window_min_ff;
      count_next = count_ff + COUNT_W'(1);
      window_close = (synced_ff && (count_next > {1'b0, resync_window_ff})) ||
                     (count_next > {1'b0, initial_window_ff});
      base = offset_ff + delay_ext;
      // Both candidate minimums are subtracted in parallel; the compare picks one.
      dev  = min_less ? (base - s1_diff_ff) : (base - window_min_ff);
      // Magnitude within tolerance, tested without negating the deviation.
      in_tol = dev[TIME_W-1] ? ($signed(dev) >= $signed(neg_tol)) : (dev <= tol_ext);
      calib_age = s1_local_ff - last_calib_ff;
      timed_out = (last_calib_ff != '0) && (s1_local_ff >= last_calib_ff) &&
                  (calib_age >= {{(LOCAL_W-TMO_W){1'b0}}, desync_timeout_ff});

      offset_in     = offset_ff;
      last_calib_in = last_calib_ff;
      window_min_in = window_min_ff;
      count_in      = count_ff;
      synced_in     = synced_ff;
      updated_in    = 1'b0;
      rejected_in   = 1'b0;
      cleared_in    = 1'b0;

      if (s1_op_ff == OP_SAMPLE) begin
         if (s1_len_ok_ff) begin
            if (window_close) begin
               if (!synced_ff || in_tol) begin
                  offset_in     = min_next - delay_ext;
                  last_calib_in = s1_local_ff;
                  synced_in     = 1'b1;
                  updated_in    = 1'b1;
               end else begin
                  rejected_in = 1'b1;
               end
               count_in      = '0;
               window_min_in = TIME_MAX_POS;
            end else begin
               count_in      = count_next;
               window_min_in = min_next;
            end
         end
      end else if (timed_out) begin
         offset_in     = TIME_MAX_POS;
         last_calib_in = '0;
         window_min_in = TIME_MAX_POS;
         count_in      = '0;
         synced_in     = 1'b0;
         cleared_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= TIME_MAX_POS;
         last_calib_ff <= '0;
         window_min_ff <= TIME_MAX_POS;
         count_ff      <= '0;
         synced_ff     <= 1'b0;
         s2_valid_ff   <= 1'b0;
      end else begin
         if (move12) begin
            offset_ff     <= offset_in;
            last_calib_ff <= last_calib_in;
            window_min_ff <= window_min_in;
            count_ff      <= count_in;
            synced_ff     <= synced_in;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
      if (s2_ready) begin
         s2_synced_ff   <= synced_in;
         s2_offset_ff   <= synced_in ? offset_in : '0;
         s2_local_ff    <= s1_local_ff;
         s2_updated_ff  <= updated_in;
         s2_rejected_ff <= rejected_in;
         s2_cleared_ff  <= cleared_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         rsp_valid_ff <= s2_valid_ff;
      end
      if (s3_ready) begin
         rsp_synced_ff   <= s2_synced_ff;
         rsp_offset_ff   <= s2_offset_ff;
         rsp_time_ff     <= s2_synced_ff ? ({1'b0, s2_local_ff} - s2_offset_ff) : '0;
         rsp_updated_ff  <= s2_updated_ff;
         rsp_rejected_ff <= s2_rejected_ff;
         rsp_cleared_ff  <= s2_cleared_ff;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.is_synced       = rsp_synced_ff;
   assign rsp_chan.clock_offset    = rsp_offset_ff;
   assign rsp_chan.synced_time     = rsp_time_ff;
   assign rsp_chan.offset_updated  = rsp_updated_ff;
   assign rsp_chan.window_rejected = rsp_rejected_ff;
   assign rsp_chan.sync_cleared    = rsp_cleared_ff;

endmodule
